// ===== rtl/gms_pkg.sv =====
// ----------------------------------------------------------------------------
// gms_pkg: shared types and constants for the grid maze search block
// Cell kinds, request codes, register indexes, payload structs and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package gms_pkg;

   localparam int GMS_MAX_ROWS       = 64;
   localparam int GMS_MAX_COLS       = 64;
   localparam int GMS_FRONTIER_DEPTH = 16384;
   localparam int GMS_COUNT_MAX      = 8191;

   // cell kinds
   localparam logic [1:0] KIND_BLOCKED = 2'd0;
   localparam logic [1:0] KIND_OPEN    = 2'd1;
   localparam logic [1:0] KIND_EXIT    = 2'd2;
   localparam logic [1:0] KIND_VISITED = 2'd3;

   // request codes
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_RUN    = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // register indexes
   localparam logic [2:0] REG_ROWS      = 3'd0;
   localparam logic [2:0] REG_COLS      = 3'd1;
   localparam logic [2:0] REG_MODE      = 3'd2;
   localparam logic [2:0] REG_START_ROW = 3'd3;
   localparam logic [2:0] REG_START_COL = 3'd4;

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] row;
      logic [5:0] col;
      logic [1:0] cell_kind;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [12:0] visited_count;
      logic        overflow;
      logic [1:0]  read_kind;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,     // sweep grid to blocked after reset
      ST_IDLE,      // take requests
      ST_READ,      // read data for a read request comes back
      ST_POP,       // issue frontier read
      ST_FETCH,     // frontier data back, issue grid read
      ST_EXAMINE,   // grid data back, decide
      ST_PUSH,      // push neighbors one per cycle
      ST_DONE       // post run result
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/gms_ram.sv =====
// ----------------------------------------------------------------------------
// gms_ram: generic single-port-write, single-port-read memory
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module gms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/grid_maze_search.sv =====
// ----------------------------------------------------------------------------
// grid_maze_search: grid of 2-bit cells with a breadth-/depth-first search
// Holds the grid and frontier in two RAMs and walks the search one step at a
// time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries write, read and run requests (valid/ready); rsp_* returns one
//   result per read or run; csr_* writes the five setup registers, which the
//   user is to do only while idle; the block does not enforce it. A write goes
//   straight into the grid RAM; a read goes through its registered read into
//   the result register. A run pops a cell from the frontier, reads and examines
//   its grid cell, marks an open cell visited and tries each direction from it
//   in turn, in range or not, pushing in-range neighbors; it ends at an exit
//   cell, an empty frontier or an out-of-range start, and posts a result.
//   Results sit in an output register; a stalled receiver holds it, and the
//   block keeps taking writes while a result waits, but a read or run waits
//   until the result register is free.
//   After reset the grid RAM is swept to blocked, one cell a cycle, over every
//   cell address, before any request is taken.
//   Configuration writes take effect at once; make them only with no run in
//   flight.
// ----------------------------------------------------------------------------
`default_nettype none
module grid_maze_search
   import gms_pkg::*;
#(
   parameter int MAX_ROWS       = GMS_MAX_ROWS,
   parameter int MAX_COLS       = GMS_MAX_COLS,
   parameter int FRONTIER_DEPTH = GMS_FRONTIER_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [6:0] csr_data
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = RW + CW;
   localparam int FW = $clog2(FRONTIER_DEPTH);
   localparam int CELLS = 1 << AW;

   // configuration
   logic [6:0] rows_ff, cols_ff;
   logic       mode_ff;
   logic [5:0] srow_ff, scol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 7'd32;
         cols_ff <= 7'd62;
         mode_ff <= 1'b0;
         srow_ff <= 6'd1;
         scol_ff <= 6'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROWS:      rows_ff <= csr_data;
            REG_COLS:      cols_ff <= csr_data;
            REG_MODE:      mode_ff <= csr_data[0];
            REG_START_ROW: srow_ff <= csr_data[5:0];
            REG_START_COL: scol_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // saturated dimensions, wide enough to hold MAX itself
   logic [8:0] nr, nc;
   always_comb begin
      nr = ({2'b0, rows_ff} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_ff};
      nc = ({2'b0, cols_ff} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_ff};
   end

   // sequencer registers
   state_type    state_ff, state_in;
   logic [AW:0]  clr_ff, clr_in;
   logic [FW-1:0] head_ff, head_in;
   logic [FW:0]  cnt_ff, cnt_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [2:0]   dir_ff, dir_in;
   logic         found_ff, found_in, ovf_ff, ovf_in;
   logic [12:0]  vis_ff, vis_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   // RAM ports
   logic          g_we;
   logic [AW-1:0] g_wa, g_ra;
   logic [1:0]    g_wd, g_rd;
   logic          f_we;
   logic [FW-1:0] f_wa, f_ra;
   logic [AW-1:0] f_wd, f_rd;

   gms_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
      .clock(clock), .wr_en(g_we), .wr_addr(g_wa), .wr_data(g_wd),
      .rd_addr(g_ra), .rd_data(g_rd)
   );

   gms_ram #(.WIDTH(AW), .DEPTH(FRONTIER_DEPTH)) u_front (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd)
   );

   // request decode
   logic req_xfer, rsp_xfer, req_inside;
   logic [AW-1:0] req_addr;
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;
   assign req_inside = ({3'b0, req_data.row} < 9'(MAX_ROWS))
                    && ({3'b0, req_data.col} < 9'(MAX_COLS));
   assign req_addr = {RW'(req_data.row), CW'(req_data.col)};

   // current cell coordinates
   logic [RW-1:0] cur_r;
   logic [CW-1:0] cur_c;
   assign cur_r = cur_ff[AW-1:CW];
   assign cur_c = cur_ff[CW-1:0];

   // neighbor of the current direction, and whether it is in range
   logic          nb_ok;
   logic [AW-1:0] nb_addr;
   always_comb begin
      nb_ok   = 1'b0;
      nb_addr = cur_ff;
      case (dir_ff)
         3'd0: begin
            nb_ok   = ({1'b0, cur_c} + 9'd1) < nc;
            nb_addr = cur_ff + AW'(1);
         end
         3'd1: begin
            nb_ok   = cur_c != '0;
            nb_addr = cur_ff - AW'(1);
         end
         3'd2: begin
            nb_ok   = cur_r != '0;
            nb_addr = {cur_r - RW'(1), cur_c};
         end
         3'd3: begin
            nb_ok   = ({1'b0, cur_r} + 9'd1) < nr;
            nb_addr = {cur_r + RW'(1), cur_c};
         end
         default: ;
      endcase
   end

   logic start_ok, front_full;
   assign start_ok   = ({3'b0, srow_ff} < nr) && ({3'b0, scol_ff} < nc);
   assign front_full = cnt_ff == (FW+1)'(FRONTIER_DEPTH);

   // push position: head + count, wrapped
   logic [FW:0]   push_sum;
   logic [FW-1:0] push_pos, top_pos;
   always_comb begin
      push_sum = {1'b0, head_ff} + cnt_ff;
      if (push_sum >= (FW+1)'(FRONTIER_DEPTH)) begin
         push_sum = push_sum - (FW+1)'(FRONTIER_DEPTH);
      end
      push_pos = push_sum[FW-1:0];
      top_pos  = push_pos - FW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == (AW+1)'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_xfer && req_data.func == FUNC_READ) begin
               state_in = ST_READ;
            end else if (req_xfer && req_data.func == FUNC_RUN) begin
               state_in = start_ok ? ST_POP : ST_DONE;
            end
         end
         ST_READ:    state_in = ST_IDLE;
         ST_POP:     state_in = (cnt_ff == '0) ? ST_DONE : ST_FETCH;
         ST_FETCH:   state_in = ST_EXAMINE;
         ST_EXAMINE: begin
            if (g_rd == KIND_EXIT)      state_in = ST_DONE;
            else if (g_rd == KIND_OPEN) state_in = ST_PUSH;
            else                        state_in = ST_POP;
         end
         ST_PUSH:    if (dir_ff == 3'd3) state_in = ST_POP;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      g_we = 1'b0; g_wa = req_addr; g_wd = req_data.cell_kind; g_ra = req_addr;
      f_we = 1'b0; f_wa = push_pos; f_wd = nb_addr; f_ra = head_ff;
      clr_in = clr_ff; head_in = head_ff; cnt_in = cnt_ff; cur_in = cur_ff;
      dir_in = dir_ff; found_in = found_ff; ovf_in = ovf_ff; vis_in = vis_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_in = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            g_we   = 1'b1;
            g_wa   = clr_ff[AW-1:0];
            g_wd   = KIND_BLOCKED;
            clr_in = clr_ff + (AW+1)'(1);
         end
         ST_IDLE: begin
            // writes need no result slot; reads and runs do
            req_ready = (req_data.func == FUNC_WRITE) || !rsp_valid_ff || rsp_ready;
            if (req_xfer && req_data.func == FUNC_WRITE && req_inside) begin
               g_we = 1'b1;
            end
            if (req_xfer && req_data.func == FUNC_READ) begin
               rsp_in = '0;
               cur_in = {AW{1'b0}};
               found_in = req_inside;
            end
            if (req_xfer && req_data.func == FUNC_RUN) begin
               head_in  = '0;
               cnt_in   = start_ok ? (FW+1)'(1) : '0;
               found_in = 1'b0;
               ovf_in   = 1'b0;
               vis_in   = '0;
               f_we     = start_ok;
               f_wa     = '0;
               f_wd     = {RW'(srow_ff), CW'(scol_ff)};
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.read_kind = found_ff ? g_rd : KIND_BLOCKED;
         end
         ST_POP: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - (FW+1)'(1);
               if (mode_ff) begin
                  f_ra = top_pos;
               end else begin
                  f_ra    = head_ff;
                  head_in = (head_ff == FW'(FRONTIER_DEPTH - 1)) ? '0 : head_ff + FW'(1);
               end
            end
         end
         ST_FETCH: begin
            g_ra   = f_rd;
            cur_in = f_rd;
         end
         ST_EXAMINE: begin
            dir_in = 3'd0;
            if (g_rd == KIND_EXIT) begin
               found_in = 1'b1;
            end else if (g_rd == KIND_OPEN) begin
               g_we = 1'b1;
               g_wa = cur_ff;
               g_wd = KIND_VISITED;
               if (vis_ff != 13'(GMS_COUNT_MAX)) vis_in = vis_ff + 13'd1;
            end
         end
         ST_PUSH: begin
            dir_in = dir_ff + 3'd1;
            if (nb_ok) begin
               if (front_full) begin
                  ovf_in = 1'b1;
               end else begin
                  f_we   = 1'b1;
                  cnt_in = cnt_ff + (FW+1)'(1);
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.found = found_ff;
            rsp_in.visited_count = vis_ff;
            rsp_in.overflow = ovf_ff;
            rsp_in.read_kind = KIND_BLOCKED;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      dir_ff   <= dir_in;
      found_ff <= found_in;
      ovf_ff   <= ovf_in;
      vis_ff   <= vis_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (FW+1)'(FRONTIER_DEPTH)) else $error("frontier count overrun");
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_DONE) |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten while held");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("request taken while busy");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && f_we) |=> cnt_ff == $past(cnt_ff) + (FW+1)'(1))
      else $error("push lost");

endmodule
`default_nettype wire
